// ----- rtl/favr_pkg.sv -----
package favr_pkg;

  // Field widths are fixed by the instruction encoding.
  localparam int NUM_REGS = 32;
  localparam int REG_AW   = $clog2(NUM_REGS);

  typedef enum logic [2:0] {
    KIND_LDI_PAIR = 3'd0,
    KIND_DEC_BRNE = 3'd1,
    KIND_ADD_ADC  = 3'd2,
    KIND_SUB_SBC  = 3'd3,
    KIND_CP_CPC   = 3'd4,
    KIND_SUBI_SBCI = 3'd5
  } kind_e;

  // Status register bit positions.
  localparam int FLAG_C = 0;
  localparam int FLAG_Z = 1;
  localparam int FLAG_N = 2;
  localparam int FLAG_V = 3;
  localparam int FLAG_S = 4;
  localparam int FLAG_H = 5;
  localparam logic [7:0] FLAGS_ALL = 8'h3F;
  localparam logic [7:0] FLAGS_DEC = 8'h1E;

  typedef struct packed {
    logic [2:0]        kind;
    logic [REG_AW-1:0] dst_reg;
    logic [7:0]        src_field;
    logic [REG_AW-1:0] second_reg;
    logic [7:0]        second_imm;
    logic [15:0]       word;
  } item_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic [7:0]  status_out;
    logic [15:0] result_value;
    logic        branch_taken;
    logic [1:0]  cycle_cost;
  } result_t;

  // Up to two register file writes per instruction; the second wins on a clash.
  typedef struct packed {
    logic              en0;
    logic [REG_AW-1:0] addr0;
    logic [7:0]        data0;
    logic              en1;
    logic [REG_AW-1:0] addr1;
    logic [7:0]        data1;
  } wr_t;

endpackage

// ----- rtl/favr_ram.sv -----
module favr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- rtl/favr_regfile.sv -----
module favr_regfile #(
  parameter int NUM_REGS = 32
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   rd_en,
  input  logic [3:0][$clog2(NUM_REGS)-1:0]       rd_addr,
  input  favr_pkg::wr_t                          wr,
  output logic [3:0][7:0]                        rd_data
);

  localparam int AW = $clog2(NUM_REGS);

  // Two write banks, each copied twice to serve four read ports. A live value
  // table records which bank holds the newest copy and whether the entry has
  // been written since reset; unwritten entries read as zero.
  logic [NUM_REGS-1:0]   lvt_valid;
  logic [NUM_REGS-1:0]   lvt_bank;
  logic [NUM_REGS-1:0]   lvt_valid_next;
  logic [NUM_REGS-1:0]   lvt_bank_next;
  logic [3:0][AW-1:0]    addr_q;
  favr_pkg::wr_t         last_wr;
  logic [7:0]            ram_q [2][4];

  for (genvar b = 0; b < 2; b++) begin : g_bank
    for (genvar g = 0; g < 2; g++) begin : g_copy
      favr_ram #(.WIDTH(8), .DEPTH(NUM_REGS)) u_ram (
        .clk     (clk),
        .we      ((b == 0) ? wr.en0 : wr.en1),
        .waddr   ((b == 0) ? AW'(wr.addr0) : AW'(wr.addr1)),
        .wdata   ((b == 0) ? wr.data0 : wr.data1),
        .re      (rd_en),
        .raddr_a (rd_addr[2*g]),
        .raddr_b (rd_addr[2*g+1]),
        .rdata_a (ram_q[b][2*g]),
        .rdata_b (ram_q[b][2*g+1])
      );
    end
  end

  // When both writes name the same entry, the second bank holds the newest copy.
  always_comb begin
    lvt_valid_next = lvt_valid;
    lvt_bank_next  = lvt_bank;
    if (wr.en0) begin
      lvt_valid_next[AW'(wr.addr0)] = 1'b1;
      lvt_bank_next[AW'(wr.addr0)]  = 1'b0;
    end
    if (wr.en1) begin
      lvt_valid_next[AW'(wr.addr1)] = 1'b1;
      lvt_bank_next[AW'(wr.addr1)]  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lvt_valid   <= '0;
      lvt_bank    <= '0;
      last_wr.en0 <= 1'b0;
      last_wr.en1 <= 1'b0;
    end else begin
      lvt_valid <= lvt_valid_next;
      lvt_bank  <= lvt_bank_next;
      if (wr.en0 || wr.en1) begin
        last_wr.en0 <= wr.en0;
        last_wr.en1 <= wr.en1;
      end
    end
    if (wr.en0 || wr.en1) begin
      last_wr.addr0 <= wr.addr0;
      last_wr.data0 <= wr.data0;
      last_wr.addr1 <= wr.addr1;
      last_wr.data1 <= wr.data1;
    end
    if (rd_en) begin
      addr_q <= rd_addr;
    end
  end

  // The most recent write may have landed at the same edge as the read, so
  // it is forwarded ahead of the memory contents.
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      if (last_wr.en1 && AW'(last_wr.addr1) == addr_q[p]) begin
        rd_data[p] = last_wr.data1;
      end else if (last_wr.en0 && AW'(last_wr.addr0) == addr_q[p]) begin
        rd_data[p] = last_wr.data0;
      end else if (!lvt_valid[addr_q[p]]) begin
        rd_data[p] = 8'h00;
      end else if (lvt_bank[addr_q[p]]) begin
        rd_data[p] = ram_q[1][p];
      end else begin
        rd_data[p] = ram_q[0][p];
      end
    end
  end

endmodule

// ----- rtl/favr_alu.sv -----
module favr_alu (
  input  favr_pkg::item_t   it,
  input  logic [15:0]       a,
  input  logic [15:0]       b_pair,
  input  logic [15:0]       pc,
  input  logic [7:0]        status,
  output favr_pkg::result_t res,
  output favr_pkg::wr_t     wr
);

  logic [15:0] b;
  logic [15:0] sum;
  logic [15:0] diff;
  logic [15:0] hc_add;
  logic [15:0] v_add;
  logic [15:0] hc_sub;
  logic [15:0] v_sub;
  logic [7:0]  st_add;
  logic [7:0]  st_sub;
  logic [7:0]  st_dec;
  logic [7:0]  dec_res;
  logic [15:0] pc_seq;
  logic [4:0]  lo_hi;

  assign b    = (it.kind == favr_pkg::KIND_SUBI_SBCI) ? it.word : b_pair;
  assign sum  = a + b;
  assign diff = a - b;

  assign hc_add = (a & b) | (b & ~sum) | (~sum & a);
  assign v_add  = (a & b & ~sum) | (~a & ~b & sum);
  assign hc_sub = (~a & b) | (b & diff) | (diff & ~a);
  assign v_sub  = (a & ~b & ~diff) | (~a & b & diff);

  always_comb begin
    st_add = status & ~favr_pkg::FLAGS_ALL;
    st_add[favr_pkg::FLAG_H] = hc_add[11];
    st_add[favr_pkg::FLAG_C] = hc_add[15];
    st_add[favr_pkg::FLAG_V] = v_add[15];
    st_add[favr_pkg::FLAG_N] = sum[15];
    st_add[favr_pkg::FLAG_Z] = (sum == 16'h0000);
    st_add[favr_pkg::FLAG_S] = sum[15] ^ v_add[15];

    st_sub = status & ~favr_pkg::FLAGS_ALL;
    st_sub[favr_pkg::FLAG_H] = hc_sub[11];
    st_sub[favr_pkg::FLAG_C] = hc_sub[15];
    st_sub[favr_pkg::FLAG_V] = v_sub[15];
    st_sub[favr_pkg::FLAG_N] = diff[15];
    st_sub[favr_pkg::FLAG_Z] = (diff == 16'h0000);
    st_sub[favr_pkg::FLAG_S] = diff[15] ^ v_sub[15];

    // Decrement keeps H and C.
    dec_res = a[7:0] - 8'd1;
    st_dec = status & ~favr_pkg::FLAGS_DEC;
    st_dec[favr_pkg::FLAG_V] = (a[7:0] == 8'h80);
    st_dec[favr_pkg::FLAG_N] = dec_res[7];
    st_dec[favr_pkg::FLAG_Z] = (dec_res == 8'h00);
    st_dec[favr_pkg::FLAG_S] = dec_res[7] ^ (a[7:0] == 8'h80);
  end

  assign pc_seq = pc + 16'd2;
  assign lo_hi  = it.dst_reg + 5'd1;

  always_comb begin
    res.next_pc      = pc;
    res.status_out   = status;
    res.result_value = 16'h0000;
    res.branch_taken = 1'b0;
    res.cycle_cost   = 2'd2;
    wr.en0   = 1'b0;
    wr.addr0 = it.dst_reg;
    wr.data0 = sum[7:0];
    wr.en1   = 1'b0;
    wr.addr1 = lo_hi;
    wr.data1 = sum[15:8];
    case (it.kind)
      favr_pkg::KIND_LDI_PAIR: begin
        res.next_pc = pc_seq;
        wr.en0   = 1'b1;
        wr.data0 = it.src_field;
        wr.en1   = 1'b1;
        wr.addr1 = it.second_reg;
        wr.data1 = it.second_imm;
      end
      favr_pkg::KIND_DEC_BRNE: begin
        res.status_out   = st_dec;
        res.result_value = {8'h00, dec_res};
        wr.en0   = 1'b1;
        wr.data0 = dec_res;
        if (dec_res != 8'h00) begin
          res.next_pc      = pc_seq + it.word;
          res.branch_taken = 1'b1;
          res.cycle_cost   = 2'd3;
        end else begin
          res.next_pc = pc_seq;
        end
      end
      favr_pkg::KIND_ADD_ADC: begin
        res.next_pc      = pc_seq;
        res.status_out   = st_add;
        res.result_value = sum;
        wr.en0 = 1'b1;
        wr.en1 = 1'b1;
      end
      favr_pkg::KIND_SUB_SBC, favr_pkg::KIND_CP_CPC, favr_pkg::KIND_SUBI_SBCI: begin
        res.next_pc      = pc_seq;
        res.status_out   = st_sub;
        res.result_value = diff;
        wr.data0 = diff[7:0];
        wr.data1 = diff[15:8];
        if (it.kind != favr_pkg::KIND_CP_CPC) begin
          wr.en0 = 1'b1;
          wr.en1 = 1'b1;
        end
        if (it.kind == favr_pkg::KIND_SUBI_SBCI) begin
          wr.addr1 = it.src_field[4:0];
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/fused_avr_alu_pair_executor_core.sv -----
// The register file is read at the input transfer edge, and the execute stage
// loads the output register when it moves on.
// Throughput: one instruction pair per cycle, held back only by result_ready;
// the register file banks are read on an input transfer and written on retire.
// Reset (rst, synchronous, active high) empties the pipeline, zeroes the program
// counter and status, and makes every register read as zero until written.
module fused_avr_alu_pair_executor_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  favr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output favr_pkg::result_t result
);

  localparam int AW = favr_pkg::REG_AW;

  // Execute stage: holds the instruction whose operands are being read out
  // of the register file memories.
  logic              s1_valid;
  favr_pkg::item_t   s1_item;
  logic              s1_fire;
  logic              accept;

  // Architectural state kept in flip-flops; the register file is in memory.
  logic [15:0]       pc;
  logic [7:0]        status;

  logic [3:0][AW-1:0] rd_addr;
  logic [3:0][7:0]    rd_data;
  favr_pkg::wr_t      alu_wr;
  favr_pkg::wr_t      wr;
  favr_pkg::result_t  alu_res;

  // The execute stage moves on whenever the output register is empty or is
  // being drained, so a result that is being drained does not block the next transfer.
  assign s1_fire    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_fire;
  assign accept     = item_valid && item_ready;

  // Read ports: 0 and 1 give the destination pair (for subtract immediate the
  // high half is named separately), 2 and 3 give the source pair. Pair
  // indices wrap round the register file.
  always_comb begin
    rd_addr[0] = AW'(item.dst_reg);
    if (item.kind == favr_pkg::KIND_SUBI_SBCI) begin
      rd_addr[1] = AW'(item.src_field);
    end else begin
      rd_addr[1] = AW'(item.dst_reg) + AW'(1);
    end
    rd_addr[2] = AW'(item.src_field);
    rd_addr[3] = AW'(item.src_field) + AW'(1);
  end

  favr_regfile #(.NUM_REGS(favr_pkg::NUM_REGS)) u_regfile (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (rd_data)
  );

  favr_alu u_alu (
    .it     (s1_item),
    .a      ({rd_data[1], rd_data[0]}),
    .b_pair ({rd_data[3], rd_data[2]}),
    .pc     (pc),
    .status (status),
    .res    (alu_res),
    .wr     (alu_wr)
  );

  // Writes only commit when the instruction retires.
  always_comb begin
    wr     = alu_wr;
    wr.en0 = alu_wr.en0 && s1_fire;
    wr.en1 = alu_wr.en1 && s1_fire;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      pc           <= 16'h0000;
      status       <= 8'h00;
    end else begin
      if (item_ready) begin
        s1_valid <= item_valid;
      end
      if (s1_fire) begin
        result_valid <= 1'b1;
        pc           <= alu_res.next_pc;
        status       <= alu_res.status_out;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
    if (accept) begin
      s1_item <= item;
    end
    if (s1_fire) begin
      result <= alu_res;
    end
  end

endmodule

// ----- rtl/favr_checker.sv -----
module favr_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_ready,
  input logic              result_valid,
  input logic              result_ready,
  input favr_pkg::result_t result
);

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result offered straight after reset");

  // A new result only follows an input transfer.
  a_result_has_source: assert property (@(posedge clk) disable iff (rst)
    ($rose(result_valid) |-> $past(item_valid && item_ready, 2)))
    else $error("result appeared without a matching transfer");

  // A stalled result holds still.
  a_result_stable: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready |=> result_valid && $stable(result)))
    else $error("stalled result changed");

  // Cost follows the branch decision.
  a_cost: assert property (@(posedge clk) disable iff (rst)
    (result_valid |-> ((result.branch_taken && result.cycle_cost == 2'd3) ||
                       (!result.branch_taken && result.cycle_cost == 2'd2))))
    else $error("cycle cost does not match branch");

  // The top two status bits are never set by any instruction.
  a_status_top: assert property (@(posedge clk) disable iff (rst)
    (result_valid |-> result.status_out[7:6] == 2'b00))
    else $error("reserved status bits set");

endmodule

bind fused_avr_alu_pair_executor_core favr_checker u_favr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
